FILE: rtl/core/cst_pkg.sv
// Shared types, codes and character tables of the C subset tokenizer.
package cst_pkg;

  // Character classes made by the front end
  typedef enum logic [3:0] {
    CL_ZERO,
    CL_SPACE,
    CL_NEWLINE,
    CL_ALPHA,
    CL_DIGIT,
    CL_LPAREN,
    CL_RPAREN,
    CL_LBRACE,
    CL_RBRACE,
    CL_SEMI,
    CL_TILDE,
    CL_MINUS,
    CL_SLASH,
    CL_STAR,
    CL_OTHER
  } char_class_t;

  typedef enum logic [3:0] {
    TK_IDENT  = 4'd0,
    TK_CONST  = 4'd1,
    TK_INT    = 4'd2,
    TK_VOID   = 4'd3,
    TK_RETURN = 4'd4,
    TK_LPAREN = 4'd5,
    TK_RPAREN = 4'd6,
    TK_LBRACE = 4'd7,
    TK_RBRACE = 4'd8,
    TK_SEMI   = 4'd9,
    TK_MINUS  = 4'd10,
    TK_TILDE  = 4'd11,
    TK_DEC    = 4'd12,
    TK_EOF    = 4'd13,
    TK_ERROR  = 4'd14
  } token_kind_t;

  typedef enum logic [1:0] {
    EC_NONE     = 2'd0,
    EC_INVALID  = 2'd1,
    EC_BADCONST = 2'd2,
    EC_UNTERM   = 2'd3
  } err_cause_t;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_MINUS,
    LM_SLASH,
    LM_LINECOM,
    LM_BLOCKCOM,
    LM_IDENT,
    LM_NUMBER,
    LM_ERROR
  } lex_mode_t;

  // Keyword matcher states
  localparam logic [3:0] KW_NONE         = 4'd0;
  localparam logic [3:0] KW_INT_START    = 4'd1;
  localparam logic [3:0] KW_INT_DONE     = 4'd3;
  localparam logic [3:0] KW_VOID_START   = 4'd4;
  localparam logic [3:0] KW_VOID_DONE    = 4'd7;
  localparam logic [3:0] KW_RETURN_START = 4'd8;
  localparam logic [3:0] KW_RETURN_DONE  = 4'd13;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  // Queue depths, powers of two
  localparam int BQ_DEPTH = 4;
  localparam int BQ_PTR_W = $clog2(BQ_DEPTH);
  localparam int BQ_CNT_W = $clog2(BQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t cls;
    if (c == CH_NUL) begin
      cls = CL_ZERO;
    end else if (c == CH_NL) begin
      cls = CL_NEWLINE;
    end else if (c inside {[8'h09:8'h0D], CH_SPACE}) begin
      cls = CL_SPACE;
    end else if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F}) begin
      cls = CL_ALPHA;
    end else if (c inside {[8'h30:8'h39]}) begin
      cls = CL_DIGIT;
    end else begin
      case (c)
        CH_LPAREN: cls = CL_LPAREN;
        CH_RPAREN: cls = CL_RPAREN;
        CH_LBRACE: cls = CL_LBRACE;
        CH_RBRACE: cls = CL_RBRACE;
        CH_SEMI:   cls = CL_SEMI;
        CH_TILDE:  cls = CL_TILDE;
        CH_MINUS:  cls = CL_MINUS;
        CH_SLASH:  cls = CL_SLASH;
        CH_STAR:   cls = CL_STAR;
        default:   cls = CL_OTHER;
      endcase
    end
    return cls;
  endfunction

  // Character that advances each keyword matcher state; zero means dead
  function automatic logic [7:0] kw_expect(logic [3:0] s);
    logic [7:0] c;
    case (s)
      4'd1:    c = 8'h6E;
      4'd2:    c = 8'h74;
      4'd4:    c = 8'h6F;
      4'd5:    c = 8'h69;
      4'd6:    c = 8'h64;
      4'd8:    c = 8'h65;
      4'd9:    c = 8'h74;
      4'd10:   c = 8'h75;
      4'd11:   c = 8'h72;
      4'd12:   c = 8'h6E;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/c_subset_tokenizer_unit.sv
// A byte is registered in the front queue, then its results in the result queue.
// Throughput: one byte per cycle; the lexer state is updated once for each byte taken,
// and a byte waits in the front queue only while the result queue lacks room for two.
// Reset (rst, synchronous) empties both queues, sets line and column to 1 and returns the
// lexer to the state between tokens; the terminator byte does all but empty the queues.
module c_subset_tokenizer_unit import cst_pkg::*; #(
  parameter int LINE_BITS  = 16,
  parameter int COL_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            char_byte,
  input  logic                  push,
  output logic                  full,
  output logic [3:0]            token_kind,
  output logic [1:0]            error_cause,
  output logic [LINE_BITS-1:0]  start_line,
  output logic [COL_BITS-1:0]   start_column,
  output logic [VALUE_BITS-1:0] const_value,
  output logic                  last_of_run,
  output logic                  empty,
  input  logic                  pop
);

  localparam int RES_W     = 7 + LINE_BITS + COL_BITS + VALUE_BITS;
  localparam int COL_LSB   = VALUE_BITS;
  localparam int LINE_LSB  = COL_LSB + COL_BITS;
  localparam int LAST_BIT  = LINE_LSB + LINE_BITS;
  localparam int CAUSE_LSB = LAST_BIT + 1;
  localparam int KIND_LSB  = CAUSE_LSB + 2;

  logic                 q_valid;
  logic                 q_take;
  char_class_t          q_cls;
  logic [7:0]           q_char;
  logic [LINE_BITS-1:0] q_line;
  logic [COL_BITS-1:0]  q_col;
  logic                 room;
  logic                 res0_valid;
  logic                 res1_valid;
  logic [RES_W-1:0]     res0;
  logic [RES_W-1:0]     res1;
  logic [RES_W-1:0]     head;

  cst_front #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_byte (char_byte),
    .push      (push),
    .full      (full),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_cls     (q_cls),
    .q_char    (q_char),
    .q_line    (q_line),
    .q_col     (q_col)
  );

  cst_back #(
    .LINE_BITS  (LINE_BITS),
    .COL_BITS   (COL_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .q_cls      (q_cls),
    .q_char     (q_char),
    .q_line     (q_line),
    .q_col      (q_col),
    .room       (room),
    .res0_valid (res0_valid),
    .res1_valid (res1_valid),
    .res0       (res0),
    .res1       (res1)
  );

  cst_resq #(
    .W (RES_W)
  ) u_resq (
    .clk       (clk),
    .rst       (rst),
    .in0_valid (res0_valid),
    .in1_valid (res1_valid),
    .in0       (res0),
    .in1       (res1),
    .room      (room),
    .empty     (empty),
    .pop       (pop),
    .dout      (head)
  );

  assign token_kind   = head[KIND_LSB +: 4];
  assign error_cause  = head[CAUSE_LSB +: 2];
  assign last_of_run  = head[LAST_BIT];
  assign start_line   = head[LINE_LSB +: LINE_BITS];
  assign start_column = head[COL_LSB +: COL_BITS];
  assign const_value  = head[0 +: VALUE_BITS];

endmodule

FILE: rtl/core/cst_front.sv
// Front end: classifies input bytes, tracks line and column, queues items.
module cst_front import cst_pkg::*; #(
  parameter int LINE_BITS = 16,
  parameter int COL_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           char_byte,
  input  logic                 push,
  output logic                 full,
  output logic                 q_valid,
  input  logic                 q_take,
  output char_class_t          q_cls,
  output logic [7:0]           q_char,
  output logic [LINE_BITS-1:0] q_line,
  output logic [COL_BITS-1:0]  q_col
);

  logic [LINE_BITS-1:0] line;
  logic [LINE_BITS-1:0] line_next;
  logic [COL_BITS-1:0]  col;
  logic [COL_BITS-1:0]  col_next;

  char_class_t          ent_cls  [BQ_DEPTH];
  logic [7:0]           ent_char [BQ_DEPTH];
  logic [LINE_BITS-1:0] ent_line [BQ_DEPTH];
  logic [COL_BITS-1:0]  ent_col  [BQ_DEPTH];

  logic [BQ_PTR_W-1:0] wr_ptr;
  logic [BQ_PTR_W-1:0] rd_ptr;
  logic [BQ_CNT_W-1:0] count;

  logic        accept;
  logic        take;
  char_class_t in_cls;

  assign full    = (count == BQ_CNT_W'(BQ_DEPTH));
  assign q_valid = (count != '0);
  assign accept  = push && !full;
  assign take    = q_take && q_valid;
  assign in_cls  = classify(char_byte);

  // Position of the next byte; the terminator restarts at line 1, column 1
  always_comb begin
    line_next = line;
    col_next  = col;
    if (in_cls == CL_ZERO) begin
      line_next = LINE_BITS'(1);
      col_next  = COL_BITS'(1);
    end else if (in_cls == CL_NEWLINE) begin
      if (line != '1) begin
        line_next = line + LINE_BITS'(1);
      end
      col_next = COL_BITS'(1);
    end else if (col != '1) begin
      col_next = col + COL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line   <= LINE_BITS'(1);
      col    <= COL_BITS'(1);
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        line   <= line_next;
        col    <= col_next;
        wr_ptr <= wr_ptr + BQ_PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + BQ_PTR_W'(1);
      end
      count <= count + BQ_CNT_W'(accept) - BQ_CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_cls[wr_ptr]  <= in_cls;
      ent_char[wr_ptr] <= char_byte;
      ent_line[wr_ptr] <= line;
      ent_col[wr_ptr]  <= col;
    end
  end

  assign q_cls  = ent_cls[rd_ptr];
  assign q_char = ent_char[rd_ptr];
  assign q_line = ent_line[rd_ptr];
  assign q_col  = ent_col[rd_ptr];

endmodule

FILE: rtl/core/cst_back.sv
// Back end: lexer state machine, up to two results per item.
module cst_back import cst_pkg::*; #(
  parameter int LINE_BITS  = 16,
  parameter int COL_BITS   = 16,
  parameter int VALUE_BITS = 32,
  localparam int RES_W     = 7 + LINE_BITS + COL_BITS + VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  char_class_t          q_cls,
  input  logic [7:0]           q_char,
  input  logic [LINE_BITS-1:0] q_line,
  input  logic [COL_BITS-1:0]  q_col,
  input  logic                 room,
  output logic                 res0_valid,
  output logic                 res1_valid,
  output logic [RES_W-1:0]     res0,
  output logic [RES_W-1:0]     res1
);

  lex_mode_t             mode;
  lex_mode_t             mode_next;
  logic                  star_seen;
  logic                  star_seen_next;
  logic [3:0]            kw;
  logic [3:0]            kw_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [LINE_BITS-1:0]  tok_line;
  logic [LINE_BITS-1:0]  tok_line_next;
  logic [COL_BITS-1:0]   tok_col;
  logic [COL_BITS-1:0]   tok_col_next;

  logic                  pre_v;
  token_kind_t           pre_kind;
  err_cause_t            pre_cause;
  logic [LINE_BITS-1:0]  pre_line;
  logic [COL_BITS-1:0]   pre_col;
  logic [VALUE_BITS-1:0] pre_val;
  logic                  tail_v;
  token_kind_t           tail_kind;
  err_cause_t            tail_cause;
  logic                  do_idle;

  logic                  is_alnum;
  logic [VALUE_BITS-1:0] digit;
  token_kind_t           word_kind;

  assign q_take   = q_valid && room;
  assign is_alnum = (q_cls == CL_ALPHA) || (q_cls == CL_DIGIT);
  assign digit    = VALUE_BITS'(q_char[3:0]);

  always_comb begin
    case (kw)
      KW_INT_DONE:    word_kind = TK_INT;
      KW_VOID_DONE:   word_kind = TK_VOID;
      KW_RETURN_DONE: word_kind = TK_RETURN;
      default:        word_kind = TK_IDENT;
    endcase
  end

  // Mode taken by a byte seen between tokens
  function automatic lex_mode_t idle_mode(char_class_t cls);
    lex_mode_t m;
    case (cls)
      CL_SPACE, CL_NEWLINE, CL_LPAREN, CL_RPAREN, CL_LBRACE,
      CL_RBRACE, CL_SEMI, CL_TILDE: m = LM_IDLE;
      CL_MINUS:                     m = LM_MINUS;
      CL_SLASH:                     m = LM_SLASH;
      CL_ALPHA:                     m = LM_IDENT;
      CL_DIGIT:                     m = LM_NUMBER;
      default:                      m = LM_ERROR;
    endcase
    return m;
  endfunction

  // Next state
  always_comb begin
    mode_next = mode;
    if (q_cls == CL_ZERO) begin
      mode_next = LM_IDLE;
    end else begin
      case (mode)
        LM_IDLE: mode_next = idle_mode(q_cls);
        LM_MINUS: begin
          mode_next = (q_cls == CL_MINUS) ? LM_IDLE : idle_mode(q_cls);
        end
        LM_SLASH: begin
          if (q_cls == CL_SLASH) begin
            mode_next = LM_LINECOM;
          end else if (q_cls == CL_STAR) begin
            mode_next = LM_BLOCKCOM;
          end else begin
            mode_next = LM_ERROR;
          end
        end
        LM_LINECOM: begin
          if (q_cls == CL_NEWLINE) begin
            mode_next = LM_IDLE;
          end
        end
        LM_BLOCKCOM: begin
          if (star_seen && (q_cls == CL_SLASH)) begin
            mode_next = LM_IDLE;
          end
        end
        LM_IDENT: begin
          if (!is_alnum) begin
            mode_next = idle_mode(q_cls);
          end
        end
        LM_NUMBER: begin
          if (q_cls == CL_ALPHA) begin
            mode_next = LM_ERROR;
          end else if (q_cls != CL_DIGIT) begin
            mode_next = idle_mode(q_cls);
          end
        end
        LM_ERROR: mode_next = LM_ERROR;
        default:  mode_next = LM_IDLE;
      endcase
    end
  end

  // Results and datapath; pre is the token closed by this byte, tail the one the byte itself makes
  always_comb begin
    pre_v          = 1'b0;
    pre_kind       = TK_IDENT;
    pre_cause      = EC_NONE;
    pre_line       = tok_line;
    pre_col        = tok_col;
    pre_val        = '0;
    tail_v         = 1'b0;
    tail_kind      = TK_EOF;
    tail_cause     = EC_NONE;
    do_idle        = 1'b0;
    star_seen_next = star_seen;
    kw_next        = kw;
    acc_next       = acc;
    tok_line_next  = tok_line;
    tok_col_next   = tok_col;

    if (q_cls == CL_ZERO) begin
      case (mode)
        LM_IDENT: begin
          pre_v    = 1'b1;
          pre_kind = word_kind;
        end
        LM_NUMBER: begin
          pre_v    = 1'b1;
          pre_kind = TK_CONST;
          pre_val  = acc;
        end
        LM_MINUS: begin
          pre_v    = 1'b1;
          pre_kind = TK_MINUS;
        end
        LM_SLASH: begin
          pre_v     = 1'b1;
          pre_kind  = TK_ERROR;
          pre_cause = EC_INVALID;
        end
        LM_BLOCKCOM: begin
          pre_v     = 1'b1;
          pre_kind  = TK_ERROR;
          pre_cause = EC_UNTERM;
          pre_line  = q_line;
          pre_col   = q_col;
        end
        default: ;
      endcase
      tail_v         = 1'b1;
      tail_kind      = TK_EOF;
      star_seen_next = 1'b0;
      kw_next        = KW_NONE;
      acc_next       = '0;
      tok_line_next  = LINE_BITS'(1);
      tok_col_next   = COL_BITS'(1);
    end else begin
      case (mode)
        LM_IDLE: do_idle = 1'b1;
        LM_MINUS: begin
          pre_v = 1'b1;
          if (q_cls == CL_MINUS) begin
            pre_kind = TK_DEC;
          end else begin
            pre_kind = TK_MINUS;
            do_idle  = 1'b1;
          end
        end
        LM_SLASH: begin
          if (q_cls == CL_STAR) begin
            star_seen_next = 1'b0;
          end else if (q_cls != CL_SLASH) begin
            pre_v     = 1'b1;
            pre_kind  = TK_ERROR;
            pre_cause = EC_INVALID;
          end
        end
        LM_BLOCKCOM: begin
          if (star_seen && (q_cls == CL_SLASH)) begin
            star_seen_next = 1'b0;
          end else begin
            star_seen_next = (q_cls == CL_STAR);
          end
        end
        LM_IDENT: begin
          if (is_alnum) begin
            kw_next = (kw_expect(kw) == q_char) ? kw + 4'd1 : KW_NONE;
          end else begin
            pre_v    = 1'b1;
            pre_kind = word_kind;
            do_idle  = 1'b1;
          end
        end
        LM_NUMBER: begin
          if (q_cls == CL_DIGIT) begin
            acc_next = (acc << 3) + (acc << 1) + digit;
          end else if (q_cls == CL_ALPHA) begin
            pre_v     = 1'b1;
            pre_kind  = TK_ERROR;
            pre_cause = EC_BADCONST;
          end else begin
            pre_v    = 1'b1;
            pre_kind = TK_CONST;
            pre_val  = acc;
            do_idle  = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_idle) begin
        case (q_cls)
          CL_SPACE, CL_NEWLINE: ;
          CL_LPAREN: begin
            tail_v    = 1'b1;
            tail_kind = TK_LPAREN;
          end
          CL_RPAREN: begin
            tail_v    = 1'b1;
            tail_kind = TK_RPAREN;
          end
          CL_LBRACE: begin
            tail_v    = 1'b1;
            tail_kind = TK_LBRACE;
          end
          CL_RBRACE: begin
            tail_v    = 1'b1;
            tail_kind = TK_RBRACE;
          end
          CL_SEMI: begin
            tail_v    = 1'b1;
            tail_kind = TK_SEMI;
          end
          CL_TILDE: begin
            tail_v    = 1'b1;
            tail_kind = TK_TILDE;
          end
          CL_MINUS, CL_SLASH: begin
            tok_line_next = q_line;
            tok_col_next  = q_col;
          end
          CL_ALPHA: begin
            tok_line_next = q_line;
            tok_col_next  = q_col;
            if (q_char == CH_LOW_I) begin
              kw_next = KW_INT_START;
            end else if (q_char == CH_LOW_V) begin
              kw_next = KW_VOID_START;
            end else if (q_char == CH_LOW_R) begin
              kw_next = KW_RETURN_START;
            end else begin
              kw_next = KW_NONE;
            end
          end
          CL_DIGIT: begin
            tok_line_next = q_line;
            tok_col_next  = q_col;
            acc_next      = digit;
          end
          default: begin
            tail_v     = 1'b1;
            tail_kind  = TK_ERROR;
            tail_cause = EC_INVALID;
          end
        endcase
      end
    end

    // Pack: the earlier result goes first, last_of_run on the final one
    res0_valid = q_take && (pre_v || tail_v);
    res1_valid = q_take && pre_v && tail_v;
    res1       = {tail_kind, tail_cause, 1'b1, q_line, q_col, VALUE_BITS'(0)};
    if (pre_v) begin
      res0 = {pre_kind, pre_cause, !tail_v, pre_line, pre_col, pre_val};
    end else begin
      res0 = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= LM_IDLE;
      star_seen <= 1'b0;
      kw        <= KW_NONE;
      acc       <= '0;
      tok_line  <= LINE_BITS'(1);
      tok_col   <= COL_BITS'(1);
    end else if (q_take) begin
      mode      <= mode_next;
      star_seen <= star_seen_next;
      kw        <= kw_next;
      acc       <= acc_next;
      tok_line  <= tok_line_next;
      tok_col   <= tok_col_next;
    end
  end

endmodule

FILE: rtl/core/cst_resq.sv
// Result queue: takes up to two results a cycle, hands out one.
module cst_resq import cst_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in0_valid,
  input  logic         in1_valid,
  input  logic [W-1:0] in0,
  input  logic [W-1:0] in1,
  output logic         room,
  output logic         empty,
  input  logic         pop,
  output logic [W-1:0] dout
);

  logic [W-1:0]        mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;
  logic                take;

  // Room means space for the two results one item may bring
  assign room  = (count <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign empty = (count == '0);
  assign take  = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(in0_valid) + RQ_PTR_W'(in1_valid);
      if (take) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      count <= count + RQ_CNT_W'(in0_valid) + RQ_CNT_W'(in1_valid) - RQ_CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (in0_valid) begin
      mem[wr_ptr] <= in0;
    end
    if (in1_valid) begin
      mem[wr_ptr + RQ_PTR_W'(1)] <= in1;
    end
  end

endmodule
